FILE: sv/mbse_pkg.sv
// Types, constants and word functions shared by the multiboot stream encryptor.
package mbse_pkg;

  localparam int SIZE_W = 19;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  localparam logic CFG_SESSION_KEY = 1'b0;
  localparam logic CFG_IMAGE_SIZE  = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'ha1c1;
  localparam logic [15:0] CRC_INIT = 16'h15a0;

  localparam logic [31:0] KEY_MULT    = 32'h6177614B;
  localparam logic [31:0] KEY_MULT2   = 32'(64'(KEY_MULT) * 64'(KEY_MULT));
  localparam logic [31:0] KEY_ADD2    = KEY_MULT + 32'd1;
  localparam logic [31:0] SEAL_XOR    = 32'h20796220;
  localparam logic [31:0] SESSION_XOR = 32'h7365646F;
  localparam logic [31:0] OWN_XOR_ALT = 32'h6F646573;
  localparam logic [31:0] OWN_BASE    = 32'h00380000;
  localparam logic [31:0] OWN_MARK    = 32'h80808080;
  localparam logic [31:0] OFFSET_BASE = 32'h02000000;

  localparam logic [SIZE_W-1:0] SIZE_RESET      = 19'd512;
  localparam logic [SIZE_W:0]   MIN_IMAGE_BYTES = 20'd512;

  typedef enum logic [1:0] {
    KIND_OWN_KEY = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_BODY    = 2'd2,
    KIND_CRC     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0]       key;
    logic [15:0]       crc;
    logic [SIZE_W-1:0] offset;
    logic              active;
  } xfer_state_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] own_key_word(input logic [SIZE_W-1:0] size);
    logic [15:0] s;
    logic [31:0] base;
    logic [7:0]  mix_hi;
    logic [31:0] mix;
    s      = 16'((size - 19'h200) >> 3);
    base   = OWN_BASE | ({16'd0, s & 16'h3F80} << 1) | ({16'd0, s & 16'h4000} << 2)
           | {16'd0, s & 16'h007F};
    mix_hi = base[15:8] + base[23:16] + base[7:0];
    mix    = {mix_hi, 24'd0} | base | OWN_MARK;
    return mix[9] ? (mix ^ OWN_XOR_ALT) : (mix ^ KEY_MULT);
  endfunction

  // LSB-first CRC over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b_in);
    logic [15:0] c;
    logic [7:0]  b;
    c = crc_in;
    b = b_in;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[0]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      b = b >> 1;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_word(input logic [15:0] crc_in, input logic [31:0] w);
    logic [15:0] c;
    c = crc_byte(crc_in, w[7:0]);
    c = crc_byte(c, w[15:8]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[31:24]);
    return c;
  endfunction

  function automatic logic [31:0] encrypt(input logic [31:0] w, input logic [31:0] key,
                                          input logic [SIZE_W-1:0] offset);
    return w ^ key ^ (32'd0 - ({13'd0, offset} + OFFSET_BASE)) ^ SEAL_XOR;
  endfunction

endpackage

FILE: sv/mbse_calc.sv
// Per-item datapath: key schedule, CRC update, encryption and next transfer state.
module mbse_calc import mbse_pkg::*; #(
  parameter int HEADER_BYTES = 192
) (
  input  logic              mode,
  input  logic [31:0]       image_word,
  input  logic [31:0]       session_key_raw,
  input  logic [SIZE_W-1:0] size,
  input  xfer_state_t       cur,
  output xfer_state_t       nxt,
  output logic [1:0]        res_count,
  output res_t              res0,
  output res_t              res1
);

  localparam logic [SIZE_W-1:0] HDR_LIMIT = SIZE_W'(HEADER_BYTES);

  logic [31:0]     key1;
  logic [31:0]     key2;
  logic [15:0]     crc_new;
  logic [SIZE_W:0] off_next;
  logic            is_hdr;
  logic            is_end;
  logic [15:0]     seal_crc;
  logic [31:0]     seal_key;

  // two key advances folded into one constant multiply
  assign key1     = cur.key * KEY_MULT + 32'd1;
  assign key2     = cur.key * KEY_MULT2 + KEY_ADD2;
  assign crc_new  = crc_word(cur.crc, image_word);
  assign off_next = {1'b0, cur.offset} + (SIZE_W+1)'(4);
  assign is_hdr   = cur.offset < HDR_LIMIT;
  assign is_end   = off_next >= {1'b0, size};
  assign seal_crc = is_hdr ? cur.crc : crc_new;
  assign seal_key = is_hdr ? key1 : key2;

  always_comb begin
    nxt       = cur;
    res_count = 2'd0;
    res0      = '{word: image_word, kind: KIND_HEADER, last: 1'b1};
    res1      = '{word: encrypt({size[15:0], seal_crc}, seal_key, size),
                  kind: KIND_CRC, last: 1'b1};
    if (mode == MODE_START) begin
      nxt.key    = swap32(session_key_raw ^ SESSION_XOR);
      nxt.crc    = CRC_INIT;
      nxt.offset = '0;
      nxt.active = 1'b1;
      res_count  = 2'd1;
      res0       = '{word: own_key_word(size), kind: KIND_OWN_KEY, last: 1'b1};
    end else if (cur.active) begin
      res_count = is_end ? 2'd2 : 2'd1;
      res0.last = !is_end;
      if (!is_hdr) begin
        res0.word = encrypt(image_word, key1, cur.offset);
        res0.kind = KIND_BODY;
        nxt.crc   = crc_new;
        nxt.key   = key1;
      end
      if (is_end) begin
        nxt.key    = seal_key;
        nxt.active = 1'b0;
        nxt.offset = size;
      end else begin
        nxt.offset = off_next[SIZE_W-1:0];
      end
    end
  end

endmodule

FILE: sv/multiboot_stream_encryptor.sv
// Multiboot upload stream encryptor top level: handshakes, registers and result buffer.
//
// Accepts one item per clock while the result buffer has room. Each item is
// held in an input register, worked in one pass (two constant multiplies for
// the key, a 32-bit CRC-16 update, the encryption XOR) and written into a
// two-entry result buffer, from which results are offered on the output. An
// item that ends the image yields two results, filling both entries; all others
// yield at most one, and with out_ready held high the block runs at one item per
// cycle, pausing while an image end's CRC word waits. Data items while no upload
// is in progress are consumed with no result. Configuration writes are always taken.
module multiboot_stream_encryptor import mbse_pkg::*; #(
  parameter int MAX_IMAGE_BYTES = 262144,
  parameter int HEADER_BYTES    = 192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] image_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] send_word,
  output logic [1:0]  word_kind,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [SIZE_W:0] MAX_SIZE = (SIZE_W+1)'(MAX_IMAGE_BYTES);

  logic [31:0]       session_key_raw;
  logic [SIZE_W-1:0] image_size;
  logic [SIZE_W:0]   size_round;
  logic [SIZE_W:0]   size_clamp;
  logic [SIZE_W-1:0] size;

  logic        s1_valid;
  logic        s1_mode;
  logic [31:0] s1_word;
  logic        can_load;
  logic        s1_fire;

  xfer_state_t st;
  xfer_state_t st_next;
  logic [1:0]  res_count;
  res_t        res0;
  res_t        res1;

  logic a_valid;
  logic b_valid;
  res_t a_res;
  res_t b_res;
  logic a_valid_next;
  logic b_valid_next;
  res_t a_res_next;
  logic out_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_key_raw <= '0;
      image_size      <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SESSION_KEY: session_key_raw <= cfg_data;
        CFG_IMAGE_SIZE:  image_size      <= cfg_data[SIZE_W-1:0];
        default:         image_size      <= image_size;
      endcase
    end
  end

  assign size_round = ({1'b0, image_size} + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7);
  assign size_clamp = (size_round < MIN_IMAGE_BYTES) ? MIN_IMAGE_BYTES :
                      (size_round > MAX_SIZE) ? MAX_SIZE : size_round;
  assign size       = size_clamp[SIZE_W-1:0];

  // processing needs room for two results
  assign can_load = !a_valid || (out_ready && !b_valid);
  assign s1_fire  = s1_valid && can_load;
  assign in_ready = !s1_valid || can_load;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_word <= image_word;
    end
  end

  mbse_calc #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_calc (
    .mode           (s1_mode),
    .image_word     (s1_word),
    .session_key_raw(session_key_raw),
    .size           (size),
    .cur            (st),
    .nxt            (st_next),
    .res_count      (res_count),
    .res0           (res0),
    .res1           (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{key: '0, crc: CRC_INIT, offset: '0, active: 1'b0};
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_comb begin
    a_valid_next = a_valid;
    b_valid_next = b_valid;
    a_res_next   = a_res;
    if (out_fire) begin
      if (b_valid) begin
        a_res_next   = b_res;
        b_valid_next = 1'b0;
      end else begin
        a_valid_next = 1'b0;
      end
    end
    if (s1_fire && res_count != 2'd0) begin
      a_valid_next = 1'b1;
      a_res_next   = res0;
      b_valid_next = res_count == 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= a_valid_next;
      b_valid <= b_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    a_res <= a_res_next;
    if (s1_fire && res_count == 2'd2) begin
      b_res <= res1;
    end
  end

  assign out_valid   = a_valid;
  assign send_word   = a_res.word;
  assign word_kind   = a_res.kind;
  assign last_of_run = a_res.last;

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> a_valid)
    else $error("second result slot filled while first is empty");

  a_pair_complete: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_res.last) |-> b_valid)
    else $error("non-final result without its CRC word queued");

  a_second_is_crc: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> b_res.kind == KIND_CRC)
    else $error("second result slot holds something other than the CRC word");

  a_start_activates: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_mode == MODE_START) |=> st.active)
    else $error("start item did not open a transfer");

  a_crc_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res_count == 2'd2) |=> !st.active)
    else $error("transfer still active after CRC word");
`endif

endmodule
